[rtl/sclcw_pkg.sv]
package sclcw_pkg;

  // Codes carried in the input item's tuser bit.
  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  // Outcome of one major-axis step, passed from the step logic to the walker.
  typedef struct packed {
    logic       finish;   // step count has reached the major delta
    logic [1:0] n_cells;  // cells produced by the step, corners first, main last
  } step_ctrl_t;

endpackage

[rtl/sclcw_step.sv]
module sclcw_step #(
  parameter int COORD_WIDTH = 16
) (
  input  logic [COORD_WIDTH-1:0]   cur_x,
  input  logic [COORD_WIDTH-1:0]   cur_y,
  input  logic [COORD_WIDTH-1:0]   abs_dx,
  input  logic [COORD_WIDTH-1:0]   abs_dy,
  input  logic                     x_negative,
  input  logic                     y_negative,
  input  logic [COORD_WIDTH+2:0]   err_now,
  input  logic [COORD_WIDTH+2:0]   err_before,
  input  logic [COORD_WIDTH-1:0]   step_count,
  output sclcw_pkg::step_ctrl_t    ctrl,
  output logic [COORD_WIDTH-1:0]   new_x,
  output logic [COORD_WIDTH-1:0]   new_y,
  output logic [COORD_WIDTH+2:0]   new_err,
  output logic [2*COORD_WIDTH-1:0] cell0,
  output logic [2*COORD_WIDTH-1:0] cell1,
  output logic [2*COORD_WIDTH-1:0] cell2
);

  localparam int EW = COORD_WIDTH + 3;

  logic                     x_major;
  logic [COORD_WIDTH-1:0]   major;
  logic [COORD_WIDTH-1:0]   minor;
  logic [COORD_WIDTH:0]     two_major;
  logic [EW-1:0]            err_add;
  logic [EW-1:0]            err_sub;
  logic [EW-1:0]            err_sum;
  logic                     diag;
  logic                     s_lt;
  logic                     s_gt;
  logic [COORD_WIDTH-1:0]   x_stepped;
  logic [COORD_WIDTH-1:0]   y_stepped;
  logic [2*COORD_WIDTH-1:0] corner_a;
  logic [2*COORD_WIDTH-1:0] corner_b;
  logic [2*COORD_WIDTH-1:0] main_cell;

  always_comb begin
    x_major   = abs_dx >= abs_dy;
    major     = x_major ? abs_dx : abs_dy;
    minor     = x_major ? abs_dy : abs_dx;
    two_major = {major, 1'b0};

    err_add = err_now + EW'({minor, 1'b0});
    diag    = err_add > EW'(two_major);
    err_sub = err_add - EW'(two_major);
    err_sum = err_sub + err_before;
    s_lt    = err_sum < EW'(two_major);
    s_gt    = err_sum > EW'(two_major);

    x_stepped = x_negative ? cur_x - COORD_WIDTH'(1) : cur_x + COORD_WIDTH'(1);
    y_stepped = y_negative ? cur_y - COORD_WIDTH'(1) : cur_y + COORD_WIDTH'(1);
    new_x     = (x_major || diag) ? x_stepped : cur_x;
    new_y     = (!x_major || diag) ? y_stepped : cur_y;
    new_err   = diag ? err_sub : err_add;

    // On a diagonal move the step-back corners are the old position on one axis.
    corner_a  = {new_y, cur_x};
    corner_b  = {cur_y, new_x};
    main_cell = {new_y, new_x};

    ctrl.finish = step_count == major;
    cell0       = main_cell;
    cell1       = main_cell;
    cell2       = main_cell;
    if (!diag) begin
      ctrl.n_cells = 2'd1;
    end else if (s_lt) begin
      ctrl.n_cells = 2'd2;
      cell0        = x_major ? corner_b : corner_a;
    end else if (s_gt) begin
      ctrl.n_cells = 2'd2;
      cell0        = x_major ? corner_a : corner_b;
    end else begin
      ctrl.n_cells = 2'd3;
      cell0        = corner_a;
      cell1        = corner_b;
    end
  end

endmodule

[rtl/supercover_line_cell_walker_unit.sv]
// Supercover line walker: one item in, one result item out, for every item.
// Latency: a result appears on the master side the cycle after its item is accepted.
// Throughput: one item per clock while the master side is ready; the step logic sits between state and result register.
// Reset (rst, synchronous, active high) clears the walker to "finished", so a next
// item before any start reports line done; queued cell storage is not reset.
module supercover_line_cell_walker_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // start_x, start_y, end_x, end_y from the lowest bit up, zero padded to bytes
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  // opcode
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // cell_x, cell_y from the lowest bit up, zero padded to bytes
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  // point_valid
  output logic m_tuser,
  // line_done
  output logic m_tlast
);

  localparam int OUT_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int EW         = COORD_WIDTH + 3;
  localparam int CW         = 2 * COORD_WIDTH;

  // Walker state.
  logic [COORD_WIDTH-1:0] cur_x;
  logic [COORD_WIDTH-1:0] cur_y;
  logic [COORD_WIDTH-1:0] abs_dx;
  logic [COORD_WIDTH-1:0] abs_dy;
  logic                   x_negative;
  logic                   y_negative;
  logic [EW-1:0]          err_now;
  logic [EW-1:0]          err_before;
  logic [COORD_WIDTH-1:0] step_count;
  logic [1:0]             pending_head;
  logic [1:0]             pending_count;
  logic                   finished_flag;
  logic [CW-1:0]          pending_cells [3];

  // Result register.
  logic          res_valid;
  logic [CW-1:0] res_cell;
  logic          res_point;
  logic          res_done;

  logic accept;

  // Start decoding.
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic signed [COORD_WIDTH:0]   dx;
  logic signed [COORD_WIDTH:0]   dy;
  logic [COORD_WIDTH:0]          mag_x;
  logic [COORD_WIDTH:0]          mag_y;

  // Step results.
  sclcw_pkg::step_ctrl_t  step_ctrl;
  logic [COORD_WIDTH-1:0] step_x;
  logic [COORD_WIDTH-1:0] step_y;
  logic [EW-1:0]          step_err;
  logic [CW-1:0]          step_cell0;
  logic [CW-1:0]          step_cell1;
  logic [CW-1:0]          step_cell2;

  // The output register frees itself whenever the downstream side takes the
  // waiting result, so a new item can be taken in the same cycle.
  assign s_tready = !res_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign m_tvalid = res_valid;
  assign m_tdata  = OUT_DATA_W'(res_cell);
  assign m_tuser  = res_point;
  assign m_tlast  = res_done;

  always_comb begin
    start_x = s_tdata[COORD_WIDTH-1:0];
    start_y = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    end_x   = s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
    end_y   = s_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH];
    dx      = (COORD_WIDTH+1)'(end_x) - (COORD_WIDTH+1)'(start_x);
    dy      = (COORD_WIDTH+1)'(end_y) - (COORD_WIDTH+1)'(start_y);
    mag_x   = dx[COORD_WIDTH] ? -dx : dx;
    mag_y   = dy[COORD_WIDTH] ? -dy : dy;
  end

  sclcw_step #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_step (
    .cur_x      (cur_x),
    .cur_y      (cur_y),
    .abs_dx     (abs_dx),
    .abs_dy     (abs_dy),
    .x_negative (x_negative),
    .y_negative (y_negative),
    .err_now    (err_now),
    .err_before (err_before),
    .step_count (step_count),
    .ctrl       (step_ctrl),
    .new_x      (step_x),
    .new_y      (step_y),
    .new_err    (step_err),
    .cell0      (step_cell0),
    .cell1      (step_cell1),
    .cell2      (step_cell2)
  );

  // Control state. A next item first drains the queue; only an empty queue
  // makes the walker take a major-axis step, whose first cell is returned at
  // once while the rest wait in the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x         <= '0;
      cur_y         <= '0;
      abs_dx        <= '0;
      abs_dy        <= '0;
      x_negative    <= 1'b0;
      y_negative    <= 1'b0;
      err_now       <= '0;
      err_before    <= '0;
      step_count    <= '0;
      pending_head  <= '0;
      pending_count <= '0;
      finished_flag <= 1'b1;
      res_valid     <= 1'b0;
      res_point     <= 1'b0;
      res_done      <= 1'b0;
    end else begin
      if (accept) begin
        res_valid <= 1'b1;
        if (s_tuser == sclcw_pkg::OP_START) begin
          x_negative    <= dx[COORD_WIDTH];
          y_negative    <= dy[COORD_WIDTH];
          abs_dx        <= mag_x[COORD_WIDTH-1:0];
          abs_dy        <= mag_y[COORD_WIDTH-1:0];
          cur_x         <= start_x;
          cur_y         <= start_y;
          err_now       <= (mag_x[COORD_WIDTH-1:0] >= mag_y[COORD_WIDTH-1:0]) ?
                           EW'(mag_x[COORD_WIDTH-1:0]) : EW'(mag_y[COORD_WIDTH-1:0]);
          err_before    <= (mag_x[COORD_WIDTH-1:0] >= mag_y[COORD_WIDTH-1:0]) ?
                           EW'(mag_x[COORD_WIDTH-1:0]) : EW'(mag_y[COORD_WIDTH-1:0]);
          step_count    <= '0;
          pending_head  <= '0;
          pending_count <= 2'd1;
          finished_flag <= 1'b0;
          res_point     <= 1'b0;
          res_done      <= 1'b0;
        end else if (pending_head < pending_count) begin
          pending_head <= pending_head + 2'd1;
          res_point    <= 1'b1;
          res_done     <= 1'b0;
        end else if (finished_flag || step_ctrl.finish) begin
          // Line exhausted: the queue stays empty and every next item says done.
          pending_head  <= '0;
          pending_count <= '0;
          finished_flag <= 1'b1;
          res_point     <= 1'b0;
          res_done      <= 1'b1;
        end else begin
          cur_x         <= step_x;
          cur_y         <= step_y;
          err_now       <= step_err;
          err_before    <= step_err;
          step_count    <= step_count + COORD_WIDTH'(1);
          pending_head  <= 2'd1;
          pending_count <= step_ctrl.n_cells;
          res_point     <= 1'b1;
          res_done      <= 1'b0;
        end
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Queue storage and returned cell; neither needs a reset value.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (s_tuser == sclcw_pkg::OP_START) begin
        pending_cells[0] <= {start_y, start_x};
        res_cell         <= '0;
      end else if (pending_head < pending_count) begin
        res_cell <= pending_cells[pending_head];
      end else if (!finished_flag && !step_ctrl.finish) begin
        pending_cells[0] <= step_cell0;
        pending_cells[1] <= step_cell1;
        pending_cells[2] <= step_cell2;
        res_cell         <= step_cell0;
      end else begin
        res_cell <= '0;
      end
    end
  end

endmodule
